// ----- design/xgse_pkg.sv -----
// Package for the X-drop gapped score extension block.
// Holds the shared types, codes, score constants and residue helper.
// No dependencies.
package xgse_pkg;

	// Defaults of the top level parameters
	localparam int unsigned MAX_LEN_DEF  = 4096;
	localparam int unsigned ALPHABET_DEF = 32;

	// Field widths fixed by the interface
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned RES_W   = 5;
	localparam int unsigned MSC_W   = 8;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDAT_W  = 16;
	localparam int unsigned BEST_W  = 20;
	localparam int unsigned AEND_W  = 13;
	localparam int unsigned BEND_W  = 12;

	// Score widths: stored scores and working arithmetic
	localparam int unsigned SCORE_W = 32;
	localparam int unsigned CALC_W  = 34;
	localparam logic signed [CALC_W-1:0] SCORE_FLOOR = -(34'sd1 <<< 30);

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_GAP_OPEN   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_GAP_EXTEND = 3'd1;
	localparam logic [CIDX_W-1:0] REG_X_DROPOFF  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LEN_A      = 3'd3;
	localparam logic [CIDX_W-1:0] REG_LEN_B      = 3'd4;
	localparam logic [CIDX_W-1:0] REG_REVERSE    = 3'd5;

	// Request function codes
	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD_MTX = 2'd0,
		FN_LOAD_A   = 2'd1,
		FN_LOAD_B   = 2'd2,
		FN_RUN      = 2'd3
	} func_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROW_START,
		ST_ROW_A,
		ST_CELL_RD,
		ST_CELL_MX,
		ST_CELL_SEL,
		ST_CELL_UPD,
		ST_ROW_END,
		ST_EXTEND,
		ST_TAIL,
		ST_DONE
	} state_t;

	// Run settings handed from the register file to the engine
	typedef struct packed {
		logic [8:0]       goe;    // gap open plus extend
		logic [7:0]       ext;    // gap extend
		logic [16:0]      xd;     // effective x-drop
		logic [LEN_W-1:0] len_a;
		logic [LEN_W-1:0] len_b;
		logic             rev;
	} cfg_t;

	// Residue code modulo the alphabet size by repeated subtraction
	function automatic logic [RES_W-1:0] alpha_mod(input logic [RES_W-1:0] code,
			input int unsigned alpha);
		logic [RES_W-1:0] r;
		r = code;
		for (int k = 0; k < 8; k++) begin
			if (32'(r) >= alpha) begin
				r = RES_W'(32'(r) - alpha);
			end
		end
		return r;
	endfunction

endpackage

// ----- design/xgse_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module xgse_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/xgse_engine.sv -----
// Load path and DP sequencer of the X-drop gapped score extension.
// Depends on xgse_pkg and xgse_ram.
module xgse_engine #(
	parameter int unsigned MAX_LEN  = xgse_pkg::MAX_LEN_DEF,
	parameter int unsigned ALPHABET = xgse_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xgse_pkg::cfg_t                cfg,
	input  logic                          start,
	output logic                          busy,
	input  logic [xgse_pkg::FUNC_W-1:0]   func,
	input  logic [xgse_pkg::POS_W-1:0]    position,
	input  logic [xgse_pkg::RES_W-1:0]    residue,
	input  logic [xgse_pkg::RES_W-1:0]    column_residue,
	input  logic signed [xgse_pkg::MSC_W-1:0] matrix_score,
	output logic                          done,
	output logic [xgse_pkg::BEST_W-1:0]   best_score,
	output logic [xgse_pkg::AEND_W-1:0]   a_end,
	output logic [xgse_pkg::BEND_W-1:0]   b_end
);

	localparam int unsigned IW  = $clog2(MAX_LEN + 2);
	localparam int unsigned BW  = IW + 1;
	localparam int unsigned SAW = $clog2(MAX_LEN);
	localparam int unsigned RAW = $clog2(MAX_LEN + 1);
	localparam int unsigned MAW = $clog2(ALPHABET * ALPHABET);
	localparam int unsigned CW  = xgse_pkg::CALC_W;
	localparam int unsigned SW  = xgse_pkg::SCORE_W;
	localparam int unsigned RW  = xgse_pkg::RES_W;

	xgse_pkg::state_t state_q, state_d;

	// Run registers
	logic [IW-1:0]        a_q, b_q, first_q, last_q, bsize_q;
	logic [RW-1:0]        ra_q;
	logic signed [CW-1:0] score_q, sgr_q, best_q, rbst_q, rgap_q, s2_q, nxt_q;
	logic [IW-1:0]        aend_q, bend_q;

	// Settings widened to the working formats
	logic [IW-1:0]        m_w, n_w;
	logic signed [CW-1:0] goe_s, ext_s, xd_s;

	assign m_w   = ({4'b0, cfg.len_a} > 17'(MAX_LEN)) ? IW'(MAX_LEN) : IW'(cfg.len_a);
	assign n_w   = ({4'b0, cfg.len_b} > 17'(MAX_LEN)) ? IW'(MAX_LEN) : IW'(cfg.len_b);
	assign goe_s = CW'(signed'({1'b0, cfg.goe}));
	assign ext_s = CW'(signed'({1'b0, cfg.ext}));
	assign xd_s  = CW'(signed'({1'b0, cfg.xd}));

	// Request decode
	logic accept, run_acc;
	assign accept  = start && !busy;
	assign run_acc = accept && (func == xgse_pkg::FN_RUN);

	// Memory ports
	logic           mtx_we, sa_we, sb_we, rb_we, rg_we;
	logic [MAW-1:0] mtx_waddr, mtx_raddr;
	logic [SAW-1:0] sa_raddr, sb_raddr, ld_addr;
	logic [RAW-1:0] row_waddr, row_raddr;
	logic [SW-1:0]  rb_wdata, rg_wdata, rb_rdata, rg_rdata;
	logic [7:0]     mtx_rdata;
	logic [RW-1:0]  sa_rdata, sb_rdata;

	// Residue and matrix loads
	assign ld_addr   = SAW'(position);
	assign mtx_we    = accept && (func == xgse_pkg::FN_LOAD_MTX)
		&& (32'(residue) < ALPHABET) && (32'(column_residue) < ALPHABET);
	assign sa_we     = accept && (func == xgse_pkg::FN_LOAD_A) && (32'(position) < MAX_LEN);
	assign sb_we     = accept && (func == xgse_pkg::FN_LOAD_B) && (32'(position) < MAX_LEN);
	assign mtx_waddr = MAW'(residue) * MAW'(ALPHABET) + MAW'(column_residue);

	// Sequence read addresses, wrapped modulo the store depth
	logic [BW-1:0] a_idx, b_idx;
	always_comb begin
		if (cfg.rev) begin
			a_idx = BW'(m_w) - BW'(a_q);
		end else begin
			a_idx = (32'(a_q) >= MAX_LEN) ? BW'(32'(a_q) - MAX_LEN) : BW'(a_q);
		end
		if (cfg.rev) begin
			b_idx = BW'(n_w) + BW'(MAX_LEN - 1) - BW'(b_q);
		end else begin
			b_idx = BW'(b_q) + BW'(1);
		end
		if (32'(b_idx) >= MAX_LEN) begin
			b_idx = BW'(32'(b_idx) - MAX_LEN);
		end
	end
	assign sa_raddr  = SAW'(a_idx);
	assign sb_raddr  = SAW'(b_idx);
	assign row_raddr = RAW'(b_q);
	assign mtx_raddr = MAW'(xgse_pkg::alpha_mod(ra_q, ALPHABET)) * MAW'(ALPHABET)
		+ MAW'(xgse_pkg::alpha_mod(sb_rdata, ALPHABET));

	// Cell select step: best of diagonal, column gap and row gap
	logic signed [CW-1:0] subst, s1, s2_c, nxt_c;
	assign subst = CW'(signed'(mtx_rdata));
	assign nxt_c = rbst_q + subst;
	assign s1    = (score_q < rgap_q) ? rgap_q : score_q;
	assign s2_c  = (s1 < sgr_q) ? sgr_q : s1;

	// Cell update step: prune test and gap bookkeeping
	logic                 drop;
	logic signed [CW-1:0] s2_goe, sgr_dec, sgc_dec, sgr_new, gap_new;
	assign drop    = (best_q - s2_q) > xd_s;
	assign s2_goe  = s2_q - goe_s;
	assign sgr_dec = sgr_q - ext_s;
	assign sgc_dec = rgap_q - ext_s;
	assign sgr_new = (s2_goe > sgr_dec) ? s2_goe : sgr_dec;
	assign gap_new = (s2_goe > sgc_dec) ? s2_goe : sgc_dec;

	// Loop conditions
	logic init_go, ext_go, bsize_in;
	assign bsize_in = bsize_q <= n_w;
	assign init_go  = (bsize_q == '0) || (bsize_in && !(sgr_q < -xd_s));
	assign ext_go   = (sgr_q >= best_q - xd_s) && bsize_in;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			xgse_pkg::ST_IDLE: begin
				if (run_acc) state_d = xgse_pkg::ST_INIT;
			end
			xgse_pkg::ST_INIT: begin
				if (!init_go) state_d = (m_w != '0) ? xgse_pkg::ST_ROW_START
					: xgse_pkg::ST_DONE;
			end
			xgse_pkg::ST_ROW_START: state_d = xgse_pkg::ST_ROW_A;
			xgse_pkg::ST_ROW_A: begin
				state_d = (first_q < bsize_q) ? xgse_pkg::ST_CELL_RD : xgse_pkg::ST_ROW_END;
			end
			xgse_pkg::ST_CELL_RD:  state_d = xgse_pkg::ST_CELL_MX;
			xgse_pkg::ST_CELL_MX:  state_d = xgse_pkg::ST_CELL_SEL;
			xgse_pkg::ST_CELL_SEL: state_d = xgse_pkg::ST_CELL_UPD;
			xgse_pkg::ST_CELL_UPD: begin
				state_d = (b_q + IW'(1) < bsize_q) ? xgse_pkg::ST_CELL_RD
					: xgse_pkg::ST_ROW_END;
			end
			xgse_pkg::ST_ROW_END: begin
				if (first_q == bsize_q) state_d = xgse_pkg::ST_DONE;
				else if (last_q + IW'(1) < bsize_q) state_d = xgse_pkg::ST_TAIL;
				else state_d = xgse_pkg::ST_EXTEND;
			end
			xgse_pkg::ST_EXTEND: begin
				if (!ext_go) state_d = xgse_pkg::ST_TAIL;
			end
			xgse_pkg::ST_TAIL: begin
				state_d = (a_q + IW'(1) <= m_w) ? xgse_pkg::ST_ROW_START : xgse_pkg::ST_DONE;
			end
			xgse_pkg::ST_DONE: state_d = xgse_pkg::ST_IDLE;
			default: state_d = xgse_pkg::ST_IDLE;
		endcase
	end

	// Outputs: row store writes, busy and result strobe
	always_comb begin
		rb_we     = 1'b0;
		rg_we     = 1'b0;
		row_waddr = RAW'(bsize_q);
		rb_wdata  = SW'(xgse_pkg::SCORE_FLOOR);
		rg_wdata  = SW'(xgse_pkg::SCORE_FLOOR);
		done      = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			xgse_pkg::ST_IDLE: busy = 1'b0;
			xgse_pkg::ST_INIT: begin
				if (bsize_q == '0) begin
					rb_we    = 1'b1;
					rg_we    = 1'b1;
					rb_wdata = '0;
					rg_wdata = SW'(-goe_s);
				end else if (init_go) begin
					rb_we    = 1'b1;
					rg_we    = 1'b1;
					rb_wdata = SW'(sgr_q);
					rg_wdata = SW'(sgr_q - goe_s);
				end
			end
			xgse_pkg::ST_CELL_UPD: begin
				row_waddr = RAW'(b_q);
				if (drop) begin
					rb_we = (b_q != first_q);
				end else begin
					rb_we    = 1'b1;
					rg_we    = 1'b1;
					rb_wdata = SW'(s2_q);
					rg_wdata = SW'(gap_new);
				end
			end
			xgse_pkg::ST_EXTEND: begin
				if (ext_go) begin
					rb_we    = 1'b1;
					rg_we    = 1'b1;
					rb_wdata = SW'(sgr_q);
					rg_wdata = SW'(sgr_q - goe_s);
				end
			end
			xgse_pkg::ST_TAIL: begin
				rb_we = bsize_in;
				rg_we = bsize_in;
			end
			xgse_pkg::ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xgse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Run datapath
	always_ff @(posedge clk) begin
		case (state_q)
			xgse_pkg::ST_IDLE: begin
				bsize_q <= '0;
				first_q <= '0;
				best_q  <= '0;
				aend_q  <= '0;
				bend_q  <= '0;
				a_q     <= IW'(1);
			end
			xgse_pkg::ST_INIT: begin
				if (bsize_q == '0) begin
					sgr_q   <= -goe_s;
					bsize_q <= IW'(1);
				end else if (init_go) begin
					sgr_q   <= sgr_q - ext_s;
					bsize_q <= bsize_q + IW'(1);
				end
			end
			xgse_pkg::ST_ROW_A: begin
				ra_q    <= sa_rdata;
				score_q <= xgse_pkg::SCORE_FLOOR;
				sgr_q   <= xgse_pkg::SCORE_FLOOR;
				last_q  <= first_q;
				b_q     <= first_q;
			end
			xgse_pkg::ST_CELL_MX: begin
				rbst_q <= CW'(signed'(rb_rdata));
				rgap_q <= CW'(signed'(rg_rdata));
			end
			xgse_pkg::ST_CELL_SEL: begin
				s2_q  <= s2_c;
				nxt_q <= nxt_c;
			end
			xgse_pkg::ST_CELL_UPD: begin
				if (drop) begin
					if (b_q == first_q) first_q <= first_q + IW'(1);
				end else begin
					last_q <= b_q;
					sgr_q  <= sgr_new;
					if (s2_q > best_q) begin
						best_q <= s2_q;
						aend_q <= a_q;
						bend_q <= b_q;
					end
				end
				score_q <= nxt_q;
				b_q     <= b_q + IW'(1);
			end
			xgse_pkg::ST_ROW_END: begin
				if (first_q != bsize_q && last_q + IW'(1) < bsize_q) begin
					bsize_q <= last_q + IW'(1);
				end
			end
			xgse_pkg::ST_EXTEND: begin
				if (ext_go) begin
					sgr_q   <= sgr_q - ext_s;
					bsize_q <= bsize_q + IW'(1);
				end
			end
			xgse_pkg::ST_TAIL: begin
				if (bsize_in) bsize_q <= bsize_q + IW'(1);
				a_q <= a_q + IW'(1);
			end
			default: ;
		endcase
	end

	assign best_score = best_q[xgse_pkg::BEST_W-1:0];
	assign a_end      = xgse_pkg::AEND_W'(aend_q);
	assign b_end      = xgse_pkg::BEND_W'(bend_q);

	// Substitution table and sequence stores
	xgse_ram #(.WIDTH(8), .DEPTH(ALPHABET * ALPHABET)) u_mtx (
		.clk(clk), .we(mtx_we), .waddr(mtx_waddr), .wdata(matrix_score),
		.raddr(mtx_raddr), .rdata(mtx_rdata)
	);
	xgse_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_seq_a (
		.clk(clk), .we(sa_we), .waddr(ld_addr), .wdata(residue),
		.raddr(sa_raddr), .rdata(sa_rdata)
	);
	xgse_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_seq_b (
		.clk(clk), .we(sb_we), .waddr(ld_addr), .wdata(residue),
		.raddr(sb_raddr), .rdata(sb_rdata)
	);

	// Per-column best and gap scores
	xgse_ram #(.WIDTH(SW), .DEPTH(MAX_LEN + 1)) u_row_best (
		.clk(clk), .we(rb_we), .waddr(row_waddr), .wdata(rb_wdata),
		.raddr(row_raddr), .rdata(rb_rdata)
	);
	xgse_ram #(.WIDTH(SW), .DEPTH(MAX_LEN + 1)) u_row_gap (
		.clk(clk), .we(rg_we), .waddr(row_waddr), .wdata(rg_wdata),
		.raddr(row_raddr), .rdata(rg_rdata)
	);

endmodule

// ----- design/xdrop_gapped_score_extension.sv -----
// Top level of the X-drop gapped score extension: register file and engine.
// Depends on xgse_pkg and xgse_engine.
//
// Loads (matrix entry, A residue, B residue) are taken one per cycle while busy
// is low and never raise busy. A run raises busy from the cycle after start until
// the cycle after done. It first sets up the row store, then for each row of A
// steps through each cell in the current window and trims or widens the window,
// then gives the result. Each cell takes four steps through the row store and
// substitution table memories, which have one read port each. The result is shown
// for exactly one cycle with done high; the receiver must take it then.
module xdrop_gapped_score_extension #(
	parameter int unsigned MAX_LEN  = xgse_pkg::MAX_LEN_DEF,
	parameter int unsigned ALPHABET = xgse_pkg::ALPHABET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [xgse_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [xgse_pkg::CDAT_W-1:0]       cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [xgse_pkg::FUNC_W-1:0]       func,
	input  logic [xgse_pkg::POS_W-1:0]        position,
	input  logic [xgse_pkg::RES_W-1:0]        residue,
	input  logic [xgse_pkg::RES_W-1:0]        column_residue,
	input  logic signed [xgse_pkg::MSC_W-1:0] matrix_score,
	output logic                              done,
	output logic [xgse_pkg::BEST_W-1:0]       best_score,
	output logic [xgse_pkg::AEND_W-1:0]       a_end,
	output logic [xgse_pkg::BEND_W-1:0]       b_end
);

	logic [7:0]                 gap_open_q, gap_extend_q;
	logic [15:0]                x_dropoff_q;
	logic [xgse_pkg::LEN_W-1:0] len_a_q, len_b_q;
	logic                       reverse_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= 8'd11;
			gap_extend_q <= 8'd1;
			x_dropoff_q  <= 16'd38;
			len_a_q      <= '0;
			len_b_q      <= '0;
			reverse_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xgse_pkg::REG_GAP_OPEN:   gap_open_q   <= cfg_data[7:0];
				xgse_pkg::REG_GAP_EXTEND: gap_extend_q <= cfg_data[7:0];
				xgse_pkg::REG_X_DROPOFF:  x_dropoff_q  <= cfg_data;
				xgse_pkg::REG_LEN_A:      len_a_q      <= cfg_data[12:0];
				xgse_pkg::REG_LEN_B:      len_b_q      <= cfg_data[12:0];
				xgse_pkg::REG_REVERSE:    reverse_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Gap open cost and effective x-drop
	xgse_pkg::cfg_t cfg;
	logic [8:0]     goe;
	assign goe       = {1'b0, gap_open_q} + {1'b0, gap_extend_q};
	assign cfg.goe   = goe;
	assign cfg.ext   = gap_extend_q;
	assign cfg.xd    = ({1'b0, x_dropoff_q} < 17'(goe)) ? 17'(goe) : {1'b0, x_dropoff_q};
	assign cfg.len_a = len_a_q;
	assign cfg.len_b = len_b_q;
	assign cfg.rev   = reverse_q;

	xgse_engine #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .start(start), .busy(busy),
		.func(func), .position(position), .residue(residue),
		.column_residue(column_residue), .matrix_score(matrix_score),
		.done(done), .best_score(best_score), .a_end(a_end), .b_end(b_end)
	);

`ifndef SYNTHESIS
	// A result ends the run
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	// Loads never occupy the engine
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func != xgse_pkg::FN_RUN) |=> !busy)
		else $error("load raised busy");
	// A run request always starts a run
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == xgse_pkg::FN_RUN) |=> busy)
		else $error("run not started");
	// No best row means no positive score
	a_zero_best: assert property (@(posedge clk) disable iff (!arst_n)
		(done && a_end == '0) |-> best_score == '0)
		else $error("score without row");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for xdrop_gapped_score_extension: directed table, then random
// phases of loads and runs; each result is checked against a fixed expectation or
// a behavioral score predictor. Depends on xgse_pkg and the design top level.
module tb;
	import xgse_pkg::*;

	localparam int unsigned SEQ_LEN    = 4096;
	localparam longint      FLOOR_SC   = -(64'sd1 <<< 30);
	localparam int unsigned CYCLE_CAP  = 20_000_000;
	localparam int unsigned RAND_ITEMS = 1050;
	localparam int unsigned MIN_RUNS   = 60;

	typedef enum {K_CFG, K_REQ, K_FILL} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		int unsigned       g_open, g_ext, xd, la, lb, rv;
		func_t             fn;
		logic [POS_W-1:0]  pos;
		logic [RES_W-1:0]  res, col;
		logic signed [7:0] msc;
		bit                typed;
		logic [BEST_W-1:0] e_best;
		logic [AEND_W-1:0] e_a;
		logic [BEND_W-1:0] e_b;
	} dir_row_t;

	typedef struct {
		logic [BEST_W-1:0] best;
		logic [AEND_W-1:0] a;
		logic [BEND_W-1:0] b;
	} ext_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [CDAT_W-1:0]   cfg_data = '0;
	logic                start = 1'b0;
	logic                busy;
	logic [FUNC_W-1:0]   func = '0;
	logic [POS_W-1:0]    position = '0;
	logic [RES_W-1:0]    residue = '0;
	logic [RES_W-1:0]    column_residue = '0;
	logic signed [MSC_W-1:0] matrix_score = '0;
	logic                done;
	logic [BEST_W-1:0]   best_score;
	logic [AEND_W-1:0]   a_end;
	logic [BEND_W-1:0]   b_end;

	xdrop_gapped_score_extension dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the block: stores, row scores and register copies
	logic signed [7:0] mtx_shadow [0:1023];
	logic [RES_W-1:0]  seq_a_shadow [0:SEQ_LEN-1];
	logic [RES_W-1:0]  seq_b_shadow [0:SEQ_LEN-1];
	longint            col_best [0:SEQ_LEN];
	longint            col_gap [0:SEQ_LEN];
	int unsigned       r_open = 11, r_ext = 1, r_xd = 38, r_la = 0, r_lb = 0, r_rev = 0;

	ext_res_t    pending_scores [$];
	int unsigned fail_cnt = 0;
	int unsigned cycles = 0;
	int unsigned rand_items = 0;
	int unsigned runs_sent = 0;
	bit          no_idle = 1'b0;
	dir_row_t    dir_tab [$];

	// Score-only X-drop sweep over the shadow stores
	function automatic ext_res_t predict_extension();
		longint goe, ext, xd, sc, best, score, sgr, sgc, nxt;
		int unsigned m, n, i, a, b, bsize, first, last, aend, bend;
		logic [RES_W-1:0] ra, rb;
		ext_res_t r;
		goe = r_open + r_ext;
		ext = r_ext;
		xd = r_xd;
		m = (r_la > SEQ_LEN) ? SEQ_LEN : r_la;
		n = (r_lb > SEQ_LEN) ? SEQ_LEN : r_lb;
		if (xd < goe) xd = goe;
		best = 0; first = 0; aend = 0; bend = 0;
		sc = -goe;
		col_best[0] = 0;
		col_gap[0] = -goe;
		for (i = 1; i <= n; i++) begin
			if (sc < -xd) break;
			col_best[i] = sc;
			col_gap[i] = sc - goe;
			sc -= ext;
		end
		bsize = i;
		for (a = 1; a <= m; a++) begin
			ra = r_rev ? seq_a_shadow[(m - a) % SEQ_LEN] : seq_a_shadow[a % SEQ_LEN];
			score = FLOOR_SC;
			sgr = FLOOR_SC;
			last = first;
			for (b = first; b < bsize; b++) begin
				rb = r_rev ? seq_b_shadow[(n + SEQ_LEN - 1 - b) % SEQ_LEN]
				           : seq_b_shadow[(b + 1) % SEQ_LEN];
				sgc = col_gap[b];
				nxt = col_best[b] + longint'(mtx_shadow[{ra, rb}]);
				if (score < sgc) score = sgc;
				if (score < sgr) score = sgr;
				if (best - score > xd) begin
					if (b == first) first++;
					else col_best[b] = FLOOR_SC;
				end else begin
					last = b;
					if (score > best) begin
						best = score;
						aend = a;
						bend = b;
					end
					sgr -= ext;
					sgc -= ext;
					sgr = (score - goe > sgr) ? score - goe : sgr;
					col_gap[b] = (score - goe > sgc) ? score - goe : sgc;
					col_best[b] = score;
				end
				score = nxt;
			end
			if (first == bsize) break;
			if (last + 1 < bsize) begin
				bsize = last + 1;
			end else begin
				while (sgr >= best - xd && bsize <= n) begin
					col_best[bsize] = sgr;
					col_gap[bsize] = sgr - goe;
					sgr -= ext;
					bsize++;
				end
			end
			if (bsize <= n) begin
				col_best[bsize] = FLOOR_SC;
				col_gap[bsize] = FLOOR_SC;
				bsize++;
			end
		end
		r.best = best[BEST_W-1:0];
		r.a = aend[AEND_W-1:0];
		r.b = bend[BEND_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Drive one request; returns once the block has taken it
	task automatic send_req(input func_t fn, input logic [POS_W-1:0] pos,
			input logic [RES_W-1:0] res, input logic [RES_W-1:0] col,
			input logic signed [7:0] msc, input bit typed, input ext_res_t typed_exp);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		position <= pos;
		residue <= res;
		column_residue <= col;
		matrix_score <= msc;
		do @(posedge clk); while (busy);
		case (fn)
			FN_LOAD_MTX: mtx_shadow[{res, col}] = msc;
			FN_LOAD_A:   seq_a_shadow[pos] = res;
			FN_LOAD_B:   seq_b_shadow[pos] = res;
			FN_RUN: begin
				pending_scores.push_back(typed ? typed_exp : predict_extension());
				runs_sent++;
			end
		endcase
	endtask

	task automatic load(input func_t fn, input int unsigned pos, input int unsigned res,
			input int unsigned col, input int msc);
		ext_res_t none;
		none = '{default: '0};
		send_req(fn, pos[POS_W-1:0], res[RES_W-1:0], col[RES_W-1:0], msc[7:0], 1'b0, none);
	endtask

	// Settle: drop start, wait until no run is outstanding, then let the last load settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_scores.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all six registers, one per cycle
	task automatic write_regs(input int unsigned g_open, input int unsigned g_ext,
			input int unsigned xd, input int unsigned la, input int unsigned lb,
			input int unsigned rv);
		logic [CIDX_W-1:0] idx [6];
		int unsigned       val [6];
		wait_idle();
		idx = '{REG_GAP_OPEN, REG_GAP_EXTEND, REG_X_DROPOFF, REG_LEN_A, REG_LEN_B, REG_REVERSE};
		val = '{g_open, g_ext, xd, la, lb, rv};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k][CDAT_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		r_open = g_open & 8'hFF;
		r_ext = g_ext & 8'hFF;
		r_xd = xd & 16'hFFFF;
		r_la = la & 13'h1FFF;
		r_lb = lb & 13'h1FFF;
		r_rev = rv & 1;
	endtask

	// Whole matrix and both stores, so no read ever hits an unwritten entry
	task automatic fill_all();
		for (int r = 0; r < 32; r++)
			for (int c = 0; c < 32; c++)
				load(FN_LOAD_MTX, 0, r, c,
				     (r == c) ? int'($urandom_range(1, 12)) : int'($urandom_range(0, 13)) - 10);
		for (int p = 0; p < SEQ_LEN; p++) begin
			load(FN_LOAD_A, p, $urandom_range(0, 31), 0, 0);
			load(FN_LOAD_B, p, $urandom_range(0, 31), 0, 0);
		end
	endtask

	function automatic dir_row_t row_cfg(input int unsigned g_open, input int unsigned g_ext,
			input int unsigned xd, input int unsigned la, input int unsigned lb,
			input int unsigned rv);
		dir_row_t d;
		d = '{kind: K_CFG, fn: FN_RUN, default: '0};
		d.g_open = g_open; d.g_ext = g_ext; d.xd = xd; d.la = la; d.lb = lb; d.rv = rv;
		return d;
	endfunction

	function automatic dir_row_t row_req(input func_t fn, input int unsigned pos,
			input int unsigned res, input int unsigned col, input int msc);
		dir_row_t d;
		d = '{kind: K_REQ, fn: FN_RUN, default: '0};
		d.fn = fn; d.pos = pos[POS_W-1:0]; d.res = res[RES_W-1:0];
		d.col = col[RES_W-1:0]; d.msc = msc[7:0];
		return d;
	endfunction

	function automatic dir_row_t row_run_typed(input int unsigned eb, input int unsigned ea,
			input int unsigned ebn);
		dir_row_t d;
		d = row_req(FN_RUN, 0, 0, 0, 0);
		d.typed = 1'b1;
		d.e_best = eb[BEST_W-1:0]; d.e_a = ea[AEND_W-1:0]; d.e_b = ebn[BEND_W-1:0];
		return d;
	endfunction

	// Result check against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) begin
			if (pending_scores.size() == 0) begin
				$error("result with nothing expected: best_score %0d", best_score);
				fail_cnt <= fail_cnt + 1;
			end else begin
				ext_res_t e;
				e = pending_scores.pop_front();
				if (best_score !== e.best) begin
					$error("best_score expected %0d actual %0d", e.best, best_score);
					fail_cnt <= fail_cnt + 1;
				end
				if (a_end !== e.a) begin
					$error("a_end expected %0d actual %0d", e.a, a_end);
					fail_cnt <= fail_cnt + 1;
				end
				if (b_end !== e.b) begin
					$error("b_end expected %0d actual %0d", e.b, b_end);
					fail_cnt <= fail_cnt + 1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_CAP) begin
			$display("xdrop_gapped_score_extension: mismatch");
			$finish;
		end
	end

	initial begin
		ext_res_t    te;
		int unsigned len, nruns, shift;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		dir_tab.push_back(row_run_typed(0, 0, 0));           // empty A at reset settings
		dir_tab.push_back('{kind: K_FILL, fn: FN_RUN, default: '0});
		dir_tab.push_back(row_req(FN_LOAD_MTX, 0, 0, 0, -128));
		dir_tab.push_back(row_req(FN_LOAD_MTX, 0, 31, 31, 127));
		dir_tab.push_back(row_req(FN_LOAD_MTX, 0, 31, 0, 127));
		dir_tab.push_back(row_req(FN_LOAD_A, 4095, 31, 0, 0));
		dir_tab.push_back(row_req(FN_LOAD_B, 4095, 31, 0, 0));
		dir_tab.push_back(row_req(FN_LOAD_A, 0, 31, 0, 0));
		dir_tab.push_back(row_req(FN_LOAD_B, 1, 0, 0, 0));
		dir_tab.push_back(row_cfg(11, 1, 38, 1, 1, 0));
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(11, 1, 38, 1, 1, 1));     // backwards, lookahead wraps
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(0, 0, 0, 6, 6, 0));       // free gaps, zero drop
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(255, 255, 65535, 6, 6, 1));
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(10, 8, 40, 8191, 5, 0));  // A length saturates
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(10, 8, 40, 3, 8191, 1));  // B length saturates
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(10, 8, 40, 4096, 4096, 0));
		dir_tab.push_back(row_req(FN_RUN, 0, 0, 0, 0));
		dir_tab.push_back(row_cfg(11, 1, 38, 0, 20, 1));
		dir_tab.push_back(row_run_typed(0, 0, 0));

		foreach (dir_tab[k]) begin
			case (dir_tab[k].kind)
				K_CFG: write_regs(dir_tab[k].g_open, dir_tab[k].g_ext, dir_tab[k].xd,
				                  dir_tab[k].la, dir_tab[k].lb, dir_tab[k].rv);
				K_FILL: fill_all();
				default: begin
					te.best = dir_tab[k].e_best; te.a = dir_tab[k].e_a; te.b = dir_tab[k].e_b;
					send_req(dir_tab[k].fn, dir_tab[k].pos, dir_tab[k].res, dir_tab[k].col,
					         dir_tab[k].msc, dir_tab[k].typed, te);
				end
			endcase
		end

		// Random phases: settings, related sequences, runs mixed with stray loads
		while (rand_items < RAND_ITEMS || runs_sent < MIN_RUNS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
			write_regs(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 15),
			           ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3),
			           ($urandom_range(0, 9) == 0) ? 65535 :
			           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 60),
			           len, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : len,
			           $urandom_range(0, 1));
			shift = $urandom_range(0, 2);
			for (int p = 0; p < len + 2; p++) begin
				if ($urandom_range(0, 1) == 0) begin
					load(FN_LOAD_A, p, $urandom_range(0, 31), 0, 0);
					rand_items++;
				end
			end
			// B mostly follows A, offset to provoke gaps
			for (int p = 0; p < len + 2; p++) begin
				load(FN_LOAD_B, p, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) :
				     seq_a_shadow[(p + shift) % SEQ_LEN], 0, 0);
				rand_items++;
			end
			nruns = $urandom_range(1, 4);
			for (int r = 0; r < nruns; r++) begin
				load(FN_RUN, $urandom_range(0, 4095), $urandom_range(0, 31),
				     $urandom_range(0, 31), int'($urandom_range(0, 255)) - 128);
				rand_items++;
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 2))
						0: load(FN_LOAD_MTX, 0, $urandom_range(0, 31), $urandom_range(0, 31),
						        int'($urandom_range(0, 255)) - 128);
						1: load(FN_LOAD_A, $urandom_range(0, 4095), $urandom_range(0, 31), 0, 0);
						default: load(FN_LOAD_B, $urandom_range(0, 4095),
						              $urandom_range(0, 31), 0, 0);
					endcase
					rand_items++;
				end
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (pending_scores.size() != 0) begin
			$error("%0d expected results never arrived", pending_scores.size());
			fail_cnt = fail_cnt + 1;
		end
		if (fail_cnt == 0) begin
			$display("xdrop_gapped_score_extension: match");
		end else begin
			$display("xdrop_gapped_score_extension: mismatch");
		end
		$finish;
	end

endmodule
